// ----- hw/rtl/per_protocol_traffic_counter_macros.svh -----
// Assertion macros shared by the traffic counter RTL.
`ifndef PER_PROTOCOL_TRAFFIC_COUNTER_MACROS_SVH
`define PER_PROTOCOL_TRAFFIC_COUNTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PPTC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");
// Next-cycle implication checked outside reset.
`define PPTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/pptc_pkg.sv -----
// Package: sizes, class codes and op codes of the traffic counter.
package pptc_pkg;
    localparam int CLIENTS = 8;
    localparam int IFACES = 8;
    localparam int CL_W = 3;
    localparam int IF_W = 3;
    localparam int TS_W = 48;
    localparam int CNT_W = 32;
    // One memory row holds one set: 8 counters of 32 bits.
    localparam int ROW_W = 8 * CNT_W;
    localparam int ROWS = CLIENTS * IFACES * 2;
    localparam int ADDR_W = $clog2(ROWS);

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_CLOSE_INTERVAL = 2'd1,
        OP_OPEN_CLIENT = 2'd2,
        OP_CLOSE_CLIENT = 2'd3
    } op_t;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    function automatic logic [ADDR_W-1:0] row_addr(logic [CL_W-1:0] c,
                                                   logic [IF_W-1:0] i,
                                                   logic s);
        row_addr = {c, i, s};
    endfunction
endpackage

// ----- hw/rtl/pptc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module pptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/per_protocol_traffic_counter.sv -----
// Top level: IPv4 per-protocol packet and byte counters per client and interface.
// Packet: for each open client, read its row, then add and write back. Close interval: per
// reported interface, read both rows, wait for the output, emit the current row, copy the next
// row into it and clear the next row; open client: one row cleared per cycle; close client and
// ignored items are handled in the idle state. One item in flight; a result register decouples.
// Synchronous active-low reset clears open flags, boundaries and control; counts need no clear.
`include "per_protocol_traffic_counter_macros.svh"
module per_protocol_traffic_counter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [3:0]                  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [pptc_pkg::CL_W-1:0]   s_client,
    input  logic [pptc_pkg::IF_W-1:0]   s_iface,
    input  logic [15:0]                 s_ether_type,
    input  logic [7:0]                  s_ip_proto,
    input  logic [15:0]                 s_ip_length,
    input  logic [pptc_pkg::TS_W-1:0]   s_timestamp_us,
    input  logic [pptc_pkg::TS_W-1:0]   s_boundary_us,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [pptc_pkg::CL_W-1:0]   m_out_client,
    output logic [pptc_pkg::IF_W-1:0]   m_out_iface,
    output logic [31:0]                 m_icmp_octets,
    output logic [31:0]                 m_icmp_pkts,
    output logic [31:0]                 m_tcp_octets,
    output logic [31:0]                 m_tcp_pkts,
    output logic [31:0]                 m_udp_octets,
    output logic [31:0]                 m_udp_pkts,
    output logic [31:0]                 m_misc_octets,
    output logic [31:0]                 m_misc_pkts,
    output logic                        m_last
);
    import pptc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PKT_RD, ST_PKT_WR, ST_CI_RD, ST_CI_WAIT, ST_CI_NXT, ST_OPEN
    } state_t;

    state_t              state_reg;
    logic [3:0]          act_reg;
    logic [CLIENTS-1:0]  open_reg;
    logic [TS_W-1:0]     bound_reg [CLIENTS];
    logic [CL_W-1:0]     cl_reg;
    logic [IF_W-1:0]     if_reg;
    logic [1:0]          cls_reg;
    logic [15:0]         len_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [TS_W-1:0]     nb_reg;
    logic [IF_W:0]       cnt_reg;   // interface or row sweep counter
    logic [3:0]          n_reg;     // number of reports
    logic                set_reg;
    logic [ROW_W-1:0]    cur_reg;   // current row captured on close

    logic                m_valid_reg;
    logic [CL_W-1:0]     m_cl_reg;
    logic [IF_W-1:0]     m_if_reg;
    logic [ROW_W-1:0]    m_row_reg;
    logic                m_last_reg;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [ROW_W-1:0]    wdata;
    logic [ADDR_W-1:0]   raddr;
    logic [ROW_W-1:0]    rdata;

    logic                emit;
    logic                in_xfer;

    pptc_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_counts (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !s_valid;
    assign in_xfer   = s_valid && s_ready;
    // Emit the current row just before it is overwritten by the next row.
    assign emit      = (state_reg == ST_CI_NXT) && !set_reg;

    // Next open client at or after the scan position.
    logic [CL_W-1:0] cl_scan;
    logic            cl_found;
    always_comb begin
        cl_scan  = '0;
        cl_found = 1'b0;
        for (int c = CLIENTS - 1; c >= 0; c--) begin
            if (open_reg[c] &&
                (CL_W + 1)'(c) >= {1'b0, cl_reg} + (CL_W + 1)'(cnt_reg[0])) begin
                cl_scan  = CL_W'(c);
                cl_found = 1'b1;
            end
        end
    end

    logic [CL_W-1:0] pkt_cl;
    assign pkt_cl = cl_scan;

    // Read address and write port.
    always_comb begin
        raddr = row_addr(pkt_cl, if_reg, !(ts_reg < bound_reg[pkt_cl]));
        we    = 1'b0;
        waddr = row_addr(cl_reg, if_reg, set_reg);
        wdata = rdata;
        case (state_reg)
            ST_PKT_WR: begin
                we = 1'b1;
                for (int k = 0; k < 4; k++) begin
                    if (cls_reg == 2'(k)) begin
                        wdata[k*64 +: 32]      = rdata[k*64 +: 32] + {16'd0, len_reg};
                        wdata[k*64 + 32 +: 32] = rdata[k*64 + 32 +: 32] + 32'd1;
                    end
                end
            end
            ST_CI_RD, ST_CI_WAIT: begin
                raddr = row_addr(cl_reg, cnt_reg[IF_W-1:0], 1'b1);
            end
            ST_CI_NXT: begin
                we    = 1'b1;
                waddr = row_addr(cl_reg, cnt_reg[IF_W-1:0], set_reg);
                wdata = set_reg ? '0 : rdata;
            end
            ST_OPEN: begin
                we    = 1'b1;
                waddr = row_addr(cl_reg, cnt_reg[IF_W-1:0], set_reg);
                wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            act_reg     <= 4'd1;
            open_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CLIENTS; c++) begin
                bound_reg[c] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                act_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        len_reg <= s_ip_length;
                        ts_reg  <= s_timestamp_us;
                        nb_reg  <= s_boundary_us;
                        if_reg  <= s_iface;
                        cnt_reg <= '0;
                        set_reg <= 1'b0;
                        if (s_ip_proto == PROTO_ICMP) cls_reg <= 2'd0;
                        else if (s_ip_proto == PROTO_TCP) cls_reg <= 2'd1;
                        else if (s_ip_proto == PROTO_UDP) cls_reg <= 2'd2;
                        else cls_reg <= 2'd3;
                        case (op_t'(s_op))
                            OP_PACKET: begin
                                cl_reg <= '0;
                                if (s_ether_type == ETYPE_IPV4 && open_reg != '0) begin
                                    state_reg <= ST_PKT_RD;
                                end
                            end
                            OP_CLOSE_INTERVAL: begin
                                cl_reg <= s_client;
                                n_reg  <= (act_reg > 4'(IFACES)) ? 4'(IFACES) : act_reg;
                                if (open_reg[s_client]) begin
                                    if (act_reg != 4'd0) begin
                                        state_reg <= ST_CI_RD;
                                    end else begin
                                        // no reports: load the new boundary right away
                                        bound_reg[s_client] <= s_boundary_us;
                                    end
                                end
                            end
                            OP_OPEN_CLIENT: begin
                                cl_reg <= s_client;
                                open_reg[s_client]  <= 1'b1;
                                bound_reg[s_client] <= s_boundary_us;
                                state_reg <= ST_OPEN;
                            end
                            default: begin
                                open_reg[s_client] <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_PKT_RD: begin
                    // cnt_reg[0] set means skip past cl_reg
                    if (!cl_found) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        cl_reg    <= pkt_cl;
                        set_reg   <= !(ts_reg < bound_reg[pkt_cl]);
                        state_reg <= ST_PKT_WR;
                    end
                end
                ST_PKT_WR: begin
                    cnt_reg   <= (IF_W + 1)'(1);
                    state_reg <= ST_PKT_RD;
                end
                ST_CI_RD: begin
                    // reads of both rows of this interface are on the ports now
                    state_reg <= ST_CI_WAIT;
                end
                ST_CI_WAIT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_CI_NXT;
                        set_reg   <= 1'b0;
                    end
                end
                ST_CI_NXT: begin
                    if (!set_reg) begin
                        set_reg <= 1'b1;
                    end else if (cnt_reg + (IF_W + 1)'(1) == n_reg) begin
                        bound_reg[cl_reg] <= nb_reg;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg   <= cnt_reg + (IF_W + 1)'(1);
                        state_reg <= ST_CI_RD;
                    end
                end
                ST_OPEN: begin
                    set_reg <= !set_reg;
                    if (set_reg) begin
                        cnt_reg <= cnt_reg + (IF_W + 1)'(1);
                        if (cnt_reg == (IF_W + 1)'(IFACES - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (emit) begin
                m_valid_reg <= 1'b1;
                m_cl_reg    <= cl_reg;
                m_if_reg    <= cnt_reg[IF_W-1:0];
                m_row_reg   <= cur_reg;
                m_last_reg  <= (cnt_reg + (IF_W + 1)'(1) == n_reg);
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Current row is read while the next row address is on the port; capture it separately.
    logic [ADDR_W-1:0] cur_raddr;
    logic [ROW_W-1:0]  cur_rdata;
    assign cur_raddr = row_addr(cl_reg, cnt_reg[IF_W-1:0], 1'b0);
    pptc_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_shadow (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(cur_raddr), .rdata(cur_rdata)
    );
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CI_WAIT) begin
            cur_reg <= cur_rdata;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_client  = m_cl_reg;
    assign m_out_iface   = m_if_reg;
    assign m_icmp_octets = m_row_reg[31:0];
    assign m_icmp_pkts   = m_row_reg[63:32];
    assign m_tcp_octets  = m_row_reg[95:64];
    assign m_tcp_pkts    = m_row_reg[127:96];
    assign m_udp_octets  = m_row_reg[159:128];
    assign m_udp_pkts    = m_row_reg[191:160];
    assign m_misc_octets = m_row_reg[223:192];
    assign m_misc_pkts   = m_row_reg[255:224];
    assign m_last        = m_last_reg;

    `PPTC_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `PPTC_ASSERT_IMPL(a_no_emit_busy, aclk, aresetn, emit, !m_valid_reg || m_ready)
    `PPTC_ASSERT_NEXT(a_open_sets, aclk, aresetn, in_xfer && s_op == OP_OPEN_CLIENT, open_reg[cl_reg])
    `PPTC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)
endmodule
